@@ hw/rtl/nnsa_pkg.sv @@
// Shared types and constants for the nearest-neighbour scale address generator.
// No dependencies; used by the channel interfaces and every module of the block.
package nnsa_pkg;

   // Field widths of the channels and the register file
   localparam int COORD_W  = 13;
   localparam int DIM_W    = 14;
   localparam int STRIDE_W = 17;
   localparam int ADDR_W   = 32;
   localparam int DST_W    = 28;
   localparam int PROD_W   = COORD_W + DIM_W;
   localparam int RPROD_W  = COORD_W + STRIDE_W;

   // Configuration port
   localparam int CSR_AW = 5;
   localparam int CSR_DW = 32;

   typedef enum logic [2:0] {
      REG_SRC_WIDTH     = 3'd0,
      REG_SRC_HEIGHT    = 3'd1,
      REG_SRC_STRIDE    = 3'd2,
      REG_SRC_BASE      = 3'd3,
      REG_TARGET_WIDTH  = 3'd4,
      REG_TARGET_HEIGHT = 3'd5
   } csr_index_type;

   // Register values after reset
   localparam logic [DIM_W-1:0]    RST_SRC_WIDTH     = DIM_W'(1920);
   localparam logic [DIM_W-1:0]    RST_SRC_HEIGHT    = DIM_W'(1080);
   localparam logic [STRIDE_W-1:0] RST_SRC_STRIDE    = STRIDE_W'(7680);
   localparam logic [ADDR_W-1:0]   RST_SRC_BASE      = '0;
   localparam logic [DIM_W-1:0]    RST_TARGET_WIDTH  = DIM_W'(1280);
   localparam logic [DIM_W-1:0]    RST_TARGET_HEIGHT = DIM_W'(720);

   // Side information that rides along the divider chain unchanged
   typedef struct packed {
      logic [DST_W-1:0] dst_offset;
      logic             out_of_range;
      logic             zero_x;
      logic             zero_y;
      logic             sat_x;
      logic             sat_y;
   } side_type;

endpackage

@@ hw/rtl/nnsa_if.sv @@
// Valid/ready channel interfaces for coordinate requests and address responses.
// Depends on nnsa_pkg for field widths.
interface nnsa_req_if;
   logic                            valid;
   logic                            ready;
   logic [nnsa_pkg::COORD_W-1:0]    out_x;
   logic [nnsa_pkg::COORD_W-1:0]    out_y;

   modport source (output valid, output out_x, output out_y, input ready);
   modport sink   (input valid, input out_x, input out_y, output ready);
endinterface

interface nnsa_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [nnsa_pkg::COORD_W-1:0]    src_col;
   logic [nnsa_pkg::COORD_W-1:0]    src_row;
   logic [nnsa_pkg::ADDR_W-1:0]     src_address;
   logic [nnsa_pkg::DST_W-1:0]      dst_offset;
   logic                            out_of_range;

   modport source (output valid, output src_col, output src_row, output src_address,
                   output dst_offset, output out_of_range, input ready);
   modport sink   (input valid, input src_col, input src_row, input src_address,
                   input dst_offset, input out_of_range, output ready);
endinterface

@@ hw/rtl/nnsa_front.sv @@
// Entry stage: scales both coordinates by the source size, sets the saturation,
// zero and out-of-range flags and works out the destination offset. Depends on nnsa_pkg.
module nnsa_front #(
   parameter int QW = 13,
   parameter int CW = 27
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [nnsa_pkg::DIM_W-1:0]      img_width,
   input  logic [nnsa_pkg::DIM_W-1:0]      img_height,
   input  logic [nnsa_pkg::DIM_W-1:0]      target_width,
   input  logic [nnsa_pkg::DIM_W-1:0]      target_height,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  logic [nnsa_pkg::COORD_W-1:0]    out_x,
   input  logic [nnsa_pkg::COORD_W-1:0]    out_y,
   output logic                            out_valid,
   input  logic                            out_ready,
   output logic [CW-1:0]                   out_rem_x,
   output logic [CW-1:0]                   out_rem_y,
   output nnsa_pkg::side_type              out_side
);
   import nnsa_pkg::*;

   logic                valid_ff;
   logic [CW-1:0]       rem_x_ff, rem_y_ff, rem_x_in, rem_y_in;
   side_type            side_ff, side_in;
   logic [PROD_W-1:0]   prod_x, prod_y;
   logic [DST_W-1:0]    lin;

   assign in_ready = !valid_ff || out_ready;

   // Scaled coordinates, saturation test against the divisor shifted past the
   // top quotient bit, and the packed output offset
   always_comb begin
      prod_x   = PROD_W'(out_x) * PROD_W'(img_width);
      prod_y   = PROD_W'(out_y) * PROD_W'(img_height);
      rem_x_in = CW'(prod_x);
      rem_y_in = CW'(prod_y);
      lin      = DST_W'(out_y) * DST_W'(target_width) + DST_W'(out_x);
      side_in.dst_offset   = {lin[DST_W-3:0], 2'b00};
      side_in.out_of_range = ({1'b0, out_x} >= target_width) ||
                             ({1'b0, out_y} >= target_height);
      side_in.zero_x       = (img_width == '0) || (target_width == '0);
      side_in.zero_y       = (img_height == '0) || (target_height == '0);
      side_in.sat_x        = rem_x_in >= (CW'(target_width) << QW);
      side_in.sat_y        = rem_y_in >= (CW'(target_height) << QW);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_valid && in_ready) begin
         rem_x_ff <= rem_x_in;
         rem_y_ff <= rem_y_in;
         side_ff  <= side_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem_x = rem_x_ff;
   assign out_rem_y = rem_y_ff;
   assign out_side  = side_ff;

endmodule

@@ hw/rtl/nnsa_div_cell.sv @@
// One restoring-division cell: settles quotient bit K for both axes and hands the
// partial remainder to the next cell. Depends on nnsa_pkg.
module nnsa_div_cell #(
   parameter int QW = 13,
   parameter int CW = 27,
   parameter int K  = 0
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [nnsa_pkg::DIM_W-1:0]      target_width,
   input  logic [nnsa_pkg::DIM_W-1:0]      target_height,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  logic [CW-1:0]                   in_rem_x,
   input  logic [CW-1:0]                   in_rem_y,
   input  logic [QW-1:0]                   in_q_x,
   input  logic [QW-1:0]                   in_q_y,
   input  nnsa_pkg::side_type              in_side,
   output logic                            out_valid,
   input  logic                            out_ready,
   output logic [CW-1:0]                   out_rem_x,
   output logic [CW-1:0]                   out_rem_y,
   output logic [QW-1:0]                   out_q_x,
   output logic [QW-1:0]                   out_q_y,
   output nnsa_pkg::side_type              out_side
);
   import nnsa_pkg::*;

   logic                valid_ff;
   logic [CW-1:0]       rem_x_ff, rem_y_ff, rem_x_in, rem_y_in;
   logic [QW-1:0]       q_x_ff, q_y_ff, q_x_in, q_y_in;
   side_type            side_ff;
   logic [CW-1:0]       div_x, div_y;

   assign in_ready = !valid_ff || out_ready;

   // Trial subtract of the divisor aligned to this bit position
   always_comb begin
      div_x    = CW'(target_width) << K;
      div_y    = CW'(target_height) << K;
      rem_x_in = in_rem_x;
      rem_y_in = in_rem_y;
      q_x_in   = in_q_x;
      q_y_in   = in_q_y;
      if (in_rem_x >= div_x) begin
         rem_x_in  = in_rem_x - div_x;
         q_x_in[K] = 1'b1;
      end
      if (in_rem_y >= div_y) begin
         rem_y_in  = in_rem_y - div_y;
         q_y_in[K] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_valid && in_ready) begin
         rem_x_ff <= rem_x_in;
         rem_y_ff <= rem_y_in;
         q_x_ff   <= q_x_in;
         q_y_ff   <= q_y_in;
         side_ff  <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem_x = rem_x_ff;
   assign out_rem_y = rem_y_ff;
   assign out_q_x   = q_x_ff;
   assign out_q_y   = q_y_ff;
   assign out_side  = side_ff;

endmodule

@@ hw/rtl/nnsa_addr.sv @@
// Tail of the pipeline: clamps the quotients to the source size, multiplies the
// row by the stride, then adds base and column. Depends on nnsa_pkg.
module nnsa_addr #(
   parameter int MAX_DIM = 8192,
   parameter int QW      = 13
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [nnsa_pkg::DIM_W-1:0]      img_width,
   input  logic [nnsa_pkg::DIM_W-1:0]      img_height,
   input  logic [nnsa_pkg::STRIDE_W-1:0]   src_stride,
   input  logic [nnsa_pkg::ADDR_W-1:0]     src_base,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  logic [QW-1:0]                   in_q_x,
   input  logic [QW-1:0]                   in_q_y,
   input  nnsa_pkg::side_type              in_side,
   output logic                            out_valid,
   input  logic                            out_ready,
   output logic [nnsa_pkg::COORD_W-1:0]    src_col,
   output logic [nnsa_pkg::COORD_W-1:0]    src_row,
   output logic [nnsa_pkg::ADDR_W-1:0]     src_address,
   output logic [nnsa_pkg::DST_W-1:0]      dst_offset,
   output logic                            out_of_range
);
   import nnsa_pkg::*;

   // Clamp arithmetic width: holds MAX_DIM and any 14-bit source size
   localparam int LW = ((QW > DIM_W) ? QW : DIM_W) + 1;
   localparam logic [LW-1:0] MAX_LIM = LW'(MAX_DIM);

   logic                 a_valid_ff, b_valid_ff, a_ready;
   logic [COORD_W-1:0]   a_col_ff, a_row_ff, b_col_ff, b_row_ff, col_in, row_in;
   logic [RPROD_W-1:0]   a_rprod_ff, rprod_in;
   logic [DST_W-1:0]     a_dst_ff, b_dst_ff;
   logic                 a_oor_ff, b_oor_ff;
   logic [ADDR_W-1:0]    b_addr_ff, addr_in;
   logic [LW-1:0]        lim_x, lim_y, last_x, last_y, qx, qy, cx, cy;

   assign a_ready  = !b_valid_ff || out_ready;
   assign in_ready = !a_valid_ff || a_ready;

   // Clamp to min(source size, MAX_DIM) - 1, zero when an axis is degenerate
   always_comb begin
      lim_x  = (LW'(img_width) > MAX_LIM) ? MAX_LIM : LW'(img_width);
      lim_y  = (LW'(img_height) > MAX_LIM) ? MAX_LIM : LW'(img_height);
      last_x = lim_x - LW'(1);
      last_y = lim_y - LW'(1);
      qx     = LW'(in_q_x);
      qy     = LW'(in_q_y);
      if (in_side.zero_x) begin
         cx = '0;
      end else if (in_side.sat_x || (qx > last_x)) begin
         cx = last_x;
      end else begin
         cx = qx;
      end
      if (in_side.zero_y) begin
         cy = '0;
      end else if (in_side.sat_y || (qy > last_y)) begin
         cy = last_y;
      end else begin
         cy = qy;
      end
      col_in   = cx[COORD_W-1:0];
      row_in   = cy[COORD_W-1:0];
      rprod_in = RPROD_W'(row_in) * RPROD_W'(src_stride);
   end

   // Final address sum wraps at 32 bits
   assign addr_in = src_base + ADDR_W'(a_rprod_ff) + ADDR_W'({a_col_ff, 2'b00});

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         if (in_ready) begin
            a_valid_ff <= in_valid;
         end
         if (a_ready) begin
            b_valid_ff <= a_valid_ff;
         end
      end
      if (in_valid && in_ready) begin
         a_col_ff   <= col_in;
         a_row_ff   <= row_in;
         a_rprod_ff <= rprod_in;
         a_dst_ff   <= in_side.dst_offset;
         a_oor_ff   <= in_side.out_of_range;
      end
      if (a_valid_ff && a_ready) begin
         b_col_ff  <= a_col_ff;
         b_row_ff  <= a_row_ff;
         b_addr_ff <= addr_in;
         b_dst_ff  <= a_dst_ff;
         b_oor_ff  <= a_oor_ff;
      end
   end

   assign out_valid    = b_valid_ff;
   assign src_col      = b_col_ff;
   assign src_row      = b_row_ff;
   assign src_address  = b_addr_ff;
   assign dst_offset   = b_dst_ff;
   assign out_of_range = b_oor_ff;

endmodule

@@ hw/rtl/nearest_neighbor_scale_address_top.sv @@
// From request transfer to response a request passes one scaling stage, one division
// cell per quotient bit, the clamp/multiply stage and the address-add stage.
// Throughput: one transfer per cycle unless the response side stalls; every stage holds its
// item only while the next one is full, so the chain of division cells sets the latency but not the rate.
// Reset (synchronous) empties the pipeline and loads the register defaults.
// Depends on nnsa_pkg, nnsa_if, nnsa_front, nnsa_div_cell and nnsa_addr.
module nearest_neighbor_scale_address_top #(
   parameter int MAX_DIM = 8192
) (
   input  logic                          clock,
   input  logic                          reset,
   nnsa_req_if.sink                      req_if,
   nnsa_rsp_if.source                    rsp_if,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [nnsa_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [nnsa_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [nnsa_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                          csr_pready
);
   import nnsa_pkg::*;

   // Quotient bits needed to reach MAX_DIM, and partial remainder width
   localparam int QW = $clog2(MAX_DIM);
   localparam int CW = (PROD_W > DIM_W + QW) ? PROD_W : DIM_W + QW;

   logic [DIM_W-1:0]    img_width_ff, img_height_ff, target_width_ff, target_height_ff;
   logic [STRIDE_W-1:0] src_stride_ff;
   logic [ADDR_W-1:0]   src_base_ff;
   logic                csr_write;
   csr_index_type       csr_index;

   // Register file: written on the access phase of an APB write
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_index_type'(csr_paddr[CSR_AW-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         img_width_ff     <= RST_SRC_WIDTH;
         img_height_ff    <= RST_SRC_HEIGHT;
         src_stride_ff    <= RST_SRC_STRIDE;
         src_base_ff      <= RST_SRC_BASE;
         target_width_ff  <= RST_TARGET_WIDTH;
         target_height_ff <= RST_TARGET_HEIGHT;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_SRC_WIDTH:     img_width_ff     <= csr_pwdata[DIM_W-1:0];
            REG_SRC_HEIGHT:    img_height_ff    <= csr_pwdata[DIM_W-1:0];
            REG_SRC_STRIDE:    src_stride_ff    <= csr_pwdata[STRIDE_W-1:0];
            REG_SRC_BASE:      src_base_ff      <= csr_pwdata[ADDR_W-1:0];
            REG_TARGET_WIDTH:  target_width_ff  <= csr_pwdata[DIM_W-1:0];
            REG_TARGET_HEIGHT: target_height_ff <= csr_pwdata[DIM_W-1:0];
            default: ;
         endcase
      end
   end

   // Read-back mux
   always_comb begin
      unique case (csr_index)
         REG_SRC_WIDTH:     csr_prdata = CSR_DW'(img_width_ff);
         REG_SRC_HEIGHT:    csr_prdata = CSR_DW'(img_height_ff);
         REG_SRC_STRIDE:    csr_prdata = CSR_DW'(src_stride_ff);
         REG_SRC_BASE:      csr_prdata = CSR_DW'(src_base_ff);
         REG_TARGET_WIDTH:  csr_prdata = CSR_DW'(target_width_ff);
         REG_TARGET_HEIGHT: csr_prdata = CSR_DW'(target_height_ff);
         default:           csr_prdata = '0;
      endcase
   end

   // Stage links: index 0 leaves the front stage, index QW leaves the last cell
   logic [QW:0]     lnk_valid, lnk_ready;
   logic [CW-1:0]   lnk_rem_x [QW+1];
   logic [CW-1:0]   lnk_rem_y [QW+1];
   logic [QW-1:0]   lnk_q_x   [QW+1];
   logic [QW-1:0]   lnk_q_y   [QW+1];
   side_type        lnk_side  [QW+1];

   assign lnk_q_x[0] = '0;
   assign lnk_q_y[0] = '0;

   nnsa_front #(
      .QW (QW),
      .CW (CW)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .img_width     (img_width_ff),
      .img_height    (img_height_ff),
      .target_width  (target_width_ff),
      .target_height (target_height_ff),
      .in_valid      (req_if.valid),
      .in_ready      (req_if.ready),
      .out_x         (req_if.out_x),
      .out_y         (req_if.out_y),
      .out_valid     (lnk_valid[0]),
      .out_ready     (lnk_ready[0]),
      .out_rem_x     (lnk_rem_x[0]),
      .out_rem_y     (lnk_rem_y[0]),
      .out_side      (lnk_side[0])
   );

   // Division chain, most significant quotient bit first
   for (genvar j = 0; j < QW; j++) begin : g_cell
      nnsa_div_cell #(
         .QW (QW),
         .CW (CW),
         .K  (QW - 1 - j)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .target_width  (target_width_ff),
         .target_height (target_height_ff),
         .in_valid      (lnk_valid[j]),
         .in_ready      (lnk_ready[j]),
         .in_rem_x      (lnk_rem_x[j]),
         .in_rem_y      (lnk_rem_y[j]),
         .in_q_x        (lnk_q_x[j]),
         .in_q_y        (lnk_q_y[j]),
         .in_side       (lnk_side[j]),
         .out_valid     (lnk_valid[j+1]),
         .out_ready     (lnk_ready[j+1]),
         .out_rem_x     (lnk_rem_x[j+1]),
         .out_rem_y     (lnk_rem_y[j+1]),
         .out_q_x       (lnk_q_x[j+1]),
         .out_q_y       (lnk_q_y[j+1]),
         .out_side      (lnk_side[j+1])
      );
   end

   nnsa_addr #(
      .MAX_DIM (MAX_DIM),
      .QW      (QW)
   ) u_addr (
      .clock        (clock),
      .reset        (reset),
      .img_width    (img_width_ff),
      .img_height   (img_height_ff),
      .src_stride   (src_stride_ff),
      .src_base     (src_base_ff),
      .in_valid     (lnk_valid[QW]),
      .in_ready     (lnk_ready[QW]),
      .in_q_x       (lnk_q_x[QW]),
      .in_q_y       (lnk_q_y[QW]),
      .in_side      (lnk_side[QW]),
      .out_valid    (rsp_if.valid),
      .out_ready    (rsp_if.ready),
      .src_col      (rsp_if.src_col),
      .src_row      (rsp_if.src_row),
      .src_address  (rsp_if.src_address),
      .dst_offset   (rsp_if.dst_offset),
      .out_of_range (rsp_if.out_of_range)
   );

   // The pipeline is empty on the cycle after reset
   a_empty_after_reset: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> !rsp_if.valid)
      else $error("response valid straight after reset");

   // Chosen column and row stay inside the source image
   a_col_in_source: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && (img_width_ff != '0)) |-> (DIM_W'(rsp_if.src_col) < img_width_ff))
      else $error("source column beyond source width");

   a_row_in_source: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && (img_height_ff != '0)) |-> (DIM_W'(rsp_if.src_row) < img_height_ff))
      else $error("source row beyond source height");

   // Degenerate target leaves the column at zero and flags the coordinate
   a_zero_target: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && (target_width_ff == '0)) |->
      ((rsp_if.src_col == '0) && rsp_if.out_of_range))
      else $error("zero target width not handled");

endmodule
